FILE: hw/rtl/drb_pkg.sv
// shared types and constants for the disc reveal bitmap core
// no dependencies
`timescale 1ns / 1ps

package drb_pkg;

  localparam logic [1:0] MODE_REVEAL = 2'd0;
  localparam logic [1:0] MODE_READ   = 2'd1;
  localparam logic [1:0] MODE_WRITE  = 2'd2;
  localparam logic [1:0] MODE_CLEAR  = 2'd3;

  localparam logic [1:0] REG_ORIGIN_X = 2'd0;
  localparam logic [1:0] REG_ORIGIN_Y = 2'd1;
  localparam logic [1:0] REG_CELL     = 2'd2;
  localparam logic [1:0] REG_RADIUS   = 2'd3;

  localparam logic [15:0] CELL_SIZE_RST = 16'd100;
  localparam logic [15:0] RADIUS_RST    = 16'd5;

  localparam int unsigned DivSteps = 33;

  typedef enum logic [1:0] {
    DSEL_RAD = 2'd0,
    DSEL_X   = 2'd1,
    DSEL_Y   = 2'd2
  } div_sel_e;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic [14:0]        byte_index;
    logic [7:0]         write_byte;
  } item_t;

  typedef struct packed {
    logic [7:0]         read_byte;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
  } result_t;

  typedef struct packed {
    logic     latch;
    logic     clr_step;
    logic     div_start;
    logic     div_store;
    div_sel_e div_sel;
    logic     loop_init;
    logic     cell_chk;
    logic     cell_rd;
    logic     cell_wr;
    logic     cell_next;
    logic     byte_rd;
    logic     byte_load;
    logic     byte_wr;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic hit;
    logic last;
    logic clr_last;
  } stat_t;

endpackage

FILE: hw/rtl/drb_ram.sv
// generic single port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module drb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32768
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/drb_datapath.sv
// datapath: config registers, serial divider, disc walk counters and bitmap ram
// depends on drb_pkg and drb_ram
`timescale 1ns / 1ps

module drb_datapath #(
  parameter int unsigned GRID_SIZE        = 512,
  parameter int unsigned MAX_RADIUS_CELLS = 15
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_index_i,
  input  logic [31:0]     cfg_data_i,
  input  drb_pkg::item_t  item_i,
  input  drb_pkg::cmd_t   cmd_i,
  output drb_pkg::stat_t  stat_o,
  output drb_pkg::result_t result_o
);

  localparam int unsigned MapBytes = (GRID_SIZE * GRID_SIZE + 7) / 8;
  localparam int unsigned AW = (MapBytes > 1) ? $clog2(MapBytes) : 1;
  localparam int unsigned IW = AW + 3;
  localparam int unsigned CW = $clog2(GRID_SIZE);
  localparam int unsigned RW = $clog2(MAX_RADIUS_CELLS + 1);
  localparam int unsigned SW = 2 * RW + 2;
  localparam int unsigned BW = (AW > 15) ? AW : 15;

  // config
  logic signed [31:0] org_x_q, org_y_q;
  logic [15:0]        cell_q, rad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x_q <= '0;
      org_y_q <= '0;
      cell_q  <= drb_pkg::CELL_SIZE_RST;
      rad_q   <= drb_pkg::RADIUS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        drb_pkg::REG_ORIGIN_X: org_x_q <= cfg_data_i;
        drb_pkg::REG_ORIGIN_Y: org_y_q <= cfg_data_i;
        drb_pkg::REG_CELL:     cell_q  <= cfg_data_i[15:0];
        drb_pkg::REG_RADIUS:   rad_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // latched item
  drb_pkg::item_t item_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      item_q <= item_i;
    end
  end

  // serial restoring divider
  logic [15:0]        dvs;
  logic signed [32:0] dvd;
  logic [32:0]        quo_q, quo_d;
  logic [15:0]        rem_q, rem_d;
  logic               neg_q;
  logic [5:0]         cnt_q;
  logic [16:0]        rem_sh;
  logic               ge;

  assign dvs = (cell_q == 16'd0) ? 16'd1 : cell_q;

  always_comb begin
    unique case (cmd_i.div_sel)
      drb_pkg::DSEL_X: dvd = 33'(item_q.world_x) + 33'(org_x_q);
      drb_pkg::DSEL_Y: dvd = 33'(item_q.world_y) + 33'(org_y_q);
      default:         dvd = {17'd0, rad_q};
    endcase
  end

  assign rem_sh = {rem_q, quo_q[32]};
  assign ge     = rem_sh >= {1'b0, dvs};
  assign rem_d  = ge ? 16'(rem_sh - {1'b0, dvs}) : rem_sh[15:0];
  assign quo_d  = {quo_q[31:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.div_start) begin
      cnt_q <= 6'(drb_pkg::DivSteps);
    end else if (cnt_q != 6'd0) begin
      cnt_q <= cnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      neg_q <= dvd[32];
      quo_q <= dvd[32] ? 33'(-dvd) : 33'(dvd);
      rem_q <= '0;
    end else if (cnt_q != 6'd0) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  // quotient post processing
  logic               rem_nz;
  logic signed [34:0] qv;
  logic signed [31:0] qsat;
  logic [RW-1:0]      rcells;

  assign rem_nz = rem_q != 16'd0;
  assign qv = neg_q ? (-$signed({2'b00, quo_q}) - 35'(rem_nz)) : $signed({2'b00, quo_q});

  always_comb begin
    if (qv > 35'sd2147483647) begin
      qsat = 32'sh7fffffff;
    end else if (qv < -35'sd2147483648) begin
      qsat = 32'sh80000000;
    end else begin
      qsat = qv[31:0];
    end
    if (quo_q >= 33'(MAX_RADIUS_CELLS)) begin
      rcells = RW'(MAX_RADIUS_CELLS);
    end else begin
      rcells = RW'(quo_q + 33'(rem_nz));
    end
  end

  // result registers and radius
  logic [RW-1:0]      r_q;
  logic signed [31:0] cx_q, cy_q;
  logic [7:0]         rb_q;
  logic [7:0]         rdata;
  logic               brange;

  assign brange = 32'(item_q.byte_index) < 32'(MapBytes);

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      cx_q <= '0;
      cy_q <= '0;
      rb_q <= '0;
    end else begin
      if (cmd_i.div_store) begin
        unique case (cmd_i.div_sel)
          drb_pkg::DSEL_X: cx_q <= qsat;
          drb_pkg::DSEL_Y: cy_q <= qsat;
          default:         r_q  <= rcells;
        endcase
      end
      if (cmd_i.byte_load) begin
        rb_q <= brange ? rdata : 8'd0;
      end
    end
  end

  // disc walk
  logic signed [RW:0] dx_q, dy_q, rs;
  logic [RW-1:0]      adx, ady;
  logic [SW-1:0]      dsum, r2;
  logic signed [33:0] px, py;
  logic               in_disc, in_grid;
  logic [CW-1:0]      px_q, py_q;

  assign rs  = $signed({1'b0, r_q});
  assign adx = dx_q[RW] ? RW'(-dx_q) : dx_q[RW-1:0];
  assign ady = dy_q[RW] ? RW'(-dy_q) : dy_q[RW-1:0];
  assign dsum = SW'(adx * adx) + SW'(ady * ady);
  assign r2   = SW'(r_q * r_q);
  assign in_disc = dsum <= r2;
  assign px = 34'(cx_q) + 34'(dx_q);
  assign py = 34'(cy_q) + 34'(dy_q);
  assign in_grid = !px[33] && !py[33] && (px < 34'(GRID_SIZE)) && (py < 34'(GRID_SIZE));

  always_ff @(posedge clk_i) begin
    if (cmd_i.loop_init) begin
      dx_q <= -rs;
      dy_q <= -rs;
    end else if (cmd_i.cell_next) begin
      if (dx_q == rs) begin
        dx_q <= -rs;
        dy_q <= dy_q + (RW+1)'(1);
      end else begin
        dx_q <= dx_q + (RW+1)'(1);
      end
    end
    if (cmd_i.cell_chk) begin
      px_q <= px[CW-1:0];
      py_q <= py[CW-1:0];
    end
  end

  // bitmap address and write data
  logic [IW-1:0] idx;
  logic [AW-1:0] caddr_q, clr_q, baddr, raddr;
  logic [2:0]    bit_q;
  logic [BW-1:0] bext;
  logic          we;
  logic [7:0]    wdata;

  assign idx  = IW'(py_q) * IW'(GRID_SIZE) + IW'(px_q);
  assign bext = BW'(item_q.byte_index);
  assign baddr = bext[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.cell_rd) begin
      caddr_q <= idx[AW+2:3];
      bit_q   <= idx[2:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_q <= (clr_q == AW'(MapBytes - 1)) ? '0 : clr_q + 1'b1;
    end
  end

  always_comb begin
    we    = 1'b0;
    wdata = 8'd0;
    raddr = baddr;
    if (cmd_i.clr_step) begin
      we    = 1'b1;
      raddr = clr_q;
    end else if (cmd_i.cell_rd) begin
      raddr = idx[AW+2:3];
    end else if (cmd_i.cell_wr) begin
      we    = 1'b1;
      raddr = caddr_q;
      wdata = rdata | (8'd1 << bit_q);
    end else if (cmd_i.byte_wr) begin
      we    = brange;
      wdata = item_q.write_byte;
    end
  end

  drb_ram #(
    .Width (8),
    .Depth (MapBytes)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (we),
    .addr_i  (raddr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  assign stat_o.div_busy = cnt_q != 6'd0;
  assign stat_o.hit      = in_disc && in_grid;
  assign stat_o.last     = (dx_q == rs) && (dy_q == rs);
  assign stat_o.clr_last = clr_q == AW'(MapBytes - 1);

  assign result_o.read_byte = rb_q;
  assign result_o.center_x  = cx_q;
  assign result_o.center_y  = cy_q;

endmodule

FILE: hw/rtl/drb_ctrl.sv
// controller state machine sequencing clear, divide, disc walk and byte access
// depends on drb_pkg
`timescale 1ns / 1ps

module drb_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  logic [1:0]     mode_i,
  input  drb_pkg::stat_t stat_i,
  output drb_pkg::cmd_t  cmd_o,
  output logic           busy,
  output logic           done_o
);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_INIT   = 12'b000000000010,
    S_CLR    = 12'b000000000100,
    S_DSTART = 12'b000000001000,
    S_DWAIT  = 12'b000000010000,
    S_CHK    = 12'b000000100000,
    S_RD     = 12'b000001000000,
    S_WR     = 12'b000010000000,
    S_RDB    = 12'b000100000000,
    S_RDW    = 12'b001000000000,
    S_WRB    = 12'b010000000000,
    S_FIN    = 12'b100000000000
  } state_e;

  state_e              state_q, state_d;
  drb_pkg::div_sel_e   sel_q, sel_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      sel_q   <= drb_pkg::DSEL_RAD;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
    end
  end

  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    cmd_o   = '0;
    cmd_o.div_sel = sel_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.latch = 1'b1;
          sel_d = drb_pkg::DSEL_RAD;
          unique case (mode_i)
            drb_pkg::MODE_REVEAL: state_d = S_DSTART;
            drb_pkg::MODE_READ:   state_d = S_RDB;
            drb_pkg::MODE_WRITE:  state_d = S_WRB;
            default:              state_d = S_CLR;
          endcase
        end
      end
      S_INIT: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) state_d = S_FIN;
      end
      S_DSTART: begin
        cmd_o.div_start = 1'b1;
        state_d = S_DWAIT;
      end
      S_DWAIT: begin
        if (!stat_i.div_busy) begin
          cmd_o.div_store = 1'b1;
          unique case (sel_q)
            drb_pkg::DSEL_RAD: begin
              sel_d = drb_pkg::DSEL_X;
              state_d = S_DSTART;
            end
            drb_pkg::DSEL_X: begin
              sel_d = drb_pkg::DSEL_Y;
              state_d = S_DSTART;
            end
            default: begin
              cmd_o.loop_init = 1'b1;
              state_d = S_CHK;
            end
          endcase
        end
      end
      S_CHK: begin
        cmd_o.cell_chk = 1'b1;
        if (stat_i.hit) begin
          state_d = S_RD;
        end else begin
          cmd_o.cell_next = 1'b1;
          if (stat_i.last) state_d = S_FIN;
        end
      end
      S_RD: begin
        cmd_o.cell_rd = 1'b1;
        state_d = S_WR;
      end
      S_WR: begin
        cmd_o.cell_wr   = 1'b1;
        cmd_o.cell_next = 1'b1;
        state_d = stat_i.last ? S_FIN : S_CHK;
      end
      S_RDB: begin
        cmd_o.byte_rd = 1'b1;
        state_d = S_RDW;
      end
      S_RDW: begin
        cmd_o.byte_load = 1'b1;
        state_d = S_FIN;
      end
      S_WRB: begin
        cmd_o.byte_wr = 1'b1;
        state_d = S_FIN;
      end
      S_FIN: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy   = state_q != S_IDLE;
  assign done_o = state_q == S_FIN;

endmodule

FILE: hw/rtl/disc_reveal_bitmap_core.sv
// top level of the disc reveal bitmap core: controller plus datapath
// depends on drb_pkg, drb_ctrl, drb_datapath, drb_ram
`timescale 1ns / 1ps
// sequence to done_o: a read runs S_RDB then S_RDW, a write S_WRB, a clear sweeps
// all map bytes, a reveal runs three 33-step serial divisions (radius, x, y),
// checks each bounding-square cell and sets each in-disc, in-grid cell by
// read-modify-write on the map ram; one item at a time; each done strobe is followed
// by idle before the next accept; after reset the map ram is swept to zero with busy
// high. done_o pulses for one cycle with the result valid; the receiver cannot stall

module disc_reveal_bitmap_core #(
  parameter int unsigned GRID_SIZE        = 512,
  parameter int unsigned MAX_RADIUS_CELLS = 15
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  drb_pkg::item_t   item_i,
  output logic             done_o,
  output drb_pkg::result_t result_o,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_index_i,
  input  logic [31:0]      cfg_data_i
);

  drb_pkg::cmd_t  cmd;
  drb_pkg::stat_t stat;

  drb_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .mode_i (item_i.mode),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy   (busy),
    .done_o (done_o)
  );

  drb_datapath #(
    .GRID_SIZE        (GRID_SIZE),
    .MAX_RADIUS_CELLS (MAX_RADIUS_CELLS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .item_i      (item_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .result_o    (result_o)
  );

endmodule
